// ===== src/rctd_pkg.sv =====
package rctd_pkg;

  localparam logic [10:0] HEADER_ID_RESET = 11'h400;
  localparam logic [11:0] TARGET_WINDOW   = 12'h0FF;
  localparam int unsigned AngleOffset     = 511;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef enum logic [1:0] {
    HDR_TIMING   = 2'd0,
    HDR_SECONDS  = 2'd1,
    HDR_FRACTION = 2'd2,
    HDR_RESERVED = 2'd3
  } hdr_mode_t;

  typedef struct packed {
    logic [10:0] message_id;
    logic [63:0] message_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         object_id;
    logic               last_in_frame;
    logic [14:0]        range_cm;
    logic [13:0]        radial_speed_cm_s;
    logic signed [14:0] azimuth_centideg;
    logic signed [12:0] elevation_centideg;
    logic [7:0]         target_count;
    logic [39:0]        cycle_number;
    logic [17:0]        cycle_duration_us;
    logic [31:0]        time_seconds;
    logic [31:0]        time_fraction;
    logic [31:0]        frame_number;
  } out_word_t;

  // Raw codes of one result, as they leave the decoding front.
  typedef struct packed {
    logic [7:0]  object_id;
    logic        last;
    logic        target;
    logic [12:0] range_code;
    logic [11:0] speed_code;
    logic [9:0]  azimuth_code;
    logic [9:0]  elevation_code;
    logic [7:0]  announced;
    logic [39:0] cycle_count;
    logic [11:0] duration_code;
    logic [31:0] seconds;
    logic [31:0] fraction;
    logic [31:0] frames;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

// ===== src/radar_can_target_decoder_unit.sv =====
// A result word passes through the queue and then the output register after the message that causes it is accepted.
// Throughput: one message per cycle while in_stall is low; the two-entry queue lets the output stall without
// stopping input until the queue fills, and the output register is reloaded only when an entry is popped.
// Reset: rst is synchronous; it returns to the header phase, clears all held values and
// counters, empties the queue, drops out_valid and sets header_identifier to 0x400.
module radar_can_target_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [10:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  rctd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rctd_pkg::out_word_t out_word
);

  logic                push;
  logic                pop;
  rctd_pkg::job_t      push_job;
  rctd_pkg::job_t      pop_job;
  rctd_pkg::q_status_t q_status;

  rctd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_word  (in_word),
    .q_status (q_status),
    .in_stall (in_stall),
    .push     (push),
    .push_job (push_job)
  );

  rctd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .pop_job (pop_job),
    .q_status(q_status)
  );

  rctd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_job  (pop_job),
    .q_status (q_status),
    .pop      (pop),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_word (out_word)
  );

endmodule

// ===== src/rctd_front.sv =====
module rctd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [10:0]        cfg_data,
  input  logic               in_valid,
  input  rctd_pkg::in_word_t in_word,
  input  rctd_pkg::q_status_t q_status,
  output logic               in_stall,
  output logic               push,
  output rctd_pkg::job_t     push_job
);

  logic [10:0] header_identifier;
  logic        in_target_phase, in_target_phase_next;
  logic [7:0]  targets_left, targets_left_next;
  logic [7:0]  announced_targets, announced_targets_next;
  logic [39:0] cycle_counter_held, cycle_counter_held_next;
  logic [11:0] duration_code_held, duration_code_held_next;
  logic [31:0] seconds_held, seconds_held_next;
  logic [31:0] fraction_held, fraction_held_next;
  logic [31:0] frames_done, frames_done_next;
  logic [12:0] range_code_held, range_code_held_next;
  logic [11:0] speed_code_held, speed_code_held_next;
  logic [9:0]  azimuth_code_held, azimuth_code_held_next;
  logic [7:0]  object_held, object_held_next;

  logic                accept;
  logic [10:0]         id;
  logic [63:0]         d;
  rctd_pkg::hdr_mode_t mode;
  logic                in_window;
  logic [10:0]         id_offset;
  logic                emit_last;
  logic                emit_target;
  logic [7:0]          emit_object;
  logic [9:0]          emit_elev;

  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;
  assign id        = in_word.message_id;
  assign d         = in_word.message_data;
  assign mode      = rctd_pkg::hdr_mode_t'(d[63:62]);
  assign id_offset = id - header_identifier;
  // The upper bound is formed in 12 bits so it never wraps.
  assign in_window = (id > header_identifier) &&
                     ({1'b0, id} < ({1'b0, header_identifier} + rctd_pkg::TARGET_WINDOW));

  always_comb begin
    in_target_phase_next    = in_target_phase;
    targets_left_next       = targets_left;
    announced_targets_next  = announced_targets;
    cycle_counter_held_next = cycle_counter_held;
    duration_code_held_next = duration_code_held;
    seconds_held_next       = seconds_held;
    fraction_held_next      = fraction_held;
    frames_done_next        = frames_done;
    range_code_held_next    = range_code_held;
    speed_code_held_next    = speed_code_held;
    azimuth_code_held_next  = azimuth_code_held;
    object_held_next        = object_held;
    push        = 1'b0;
    emit_last   = 1'b0;
    emit_target = 1'b0;
    emit_object = 8'd0;
    emit_elev   = 10'd0;
    if (accept) begin
      if (!in_target_phase) begin
        if (id == header_identifier) begin
          case (mode)
            rctd_pkg::HDR_TIMING: begin
              announced_targets_next  = d[54:47];
              cycle_counter_held_next = d[46:7];
              duration_code_held_next = d[11:0];
            end
            rctd_pkg::HDR_SECONDS: begin
              seconds_held_next = d[31:0];
            end
            rctd_pkg::HDR_FRACTION: begin
              fraction_held_next = d[31:0];
              push = 1'b1;
              if (announced_targets == 8'd0) begin
                emit_last        = 1'b1;
                frames_done_next = frames_done + 32'd1;
              end else begin
                targets_left_next    = announced_targets;
                in_target_phase_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end else if (in_window) begin
        if (!d[0]) begin
          range_code_held_next   = d[13:1];
          speed_code_held_next   = d[50:39];
          azimuth_code_held_next = d[31:22];
          object_held_next       = id_offset[7:0];
        end else begin
          targets_left_next = targets_left - 8'd1;
          push        = 1'b1;
          emit_target = 1'b1;
          emit_object = object_held;
          emit_elev   = d[46:37];
          emit_last   = (targets_left_next == 8'd0);
          if (emit_last) begin
            frames_done_next     = frames_done + 32'd1;
            in_target_phase_next = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    push_job.object_id      = emit_object;
    push_job.last           = emit_last;
    push_job.target         = emit_target;
    push_job.range_code     = range_code_held;
    push_job.speed_code     = speed_code_held;
    push_job.azimuth_code   = azimuth_code_held;
    push_job.elevation_code = emit_elev;
    push_job.announced      = announced_targets;
    push_job.cycle_count    = cycle_counter_held;
    push_job.duration_code  = duration_code_held;
    push_job.seconds        = seconds_held;
    push_job.fraction       = fraction_held_next;
    push_job.frames         = frames_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_identifier  <= rctd_pkg::HEADER_ID_RESET;
      in_target_phase    <= 1'b0;
      targets_left       <= '0;
      announced_targets  <= '0;
      cycle_counter_held <= '0;
      duration_code_held <= '0;
      seconds_held       <= '0;
      fraction_held      <= '0;
      frames_done        <= '0;
      range_code_held    <= '0;
      speed_code_held    <= '0;
      azimuth_code_held  <= '0;
      object_held        <= '0;
    end else begin
      if (cfg_write) begin
        header_identifier <= cfg_data;
      end
      in_target_phase    <= in_target_phase_next;
      targets_left       <= targets_left_next;
      announced_targets  <= announced_targets_next;
      cycle_counter_held <= cycle_counter_held_next;
      duration_code_held <= duration_code_held_next;
      seconds_held       <= seconds_held_next;
      fraction_held      <= fraction_held_next;
      frames_done        <= frames_done_next;
      range_code_held    <= range_code_held_next;
      speed_code_held    <= speed_code_held_next;
      azimuth_code_held  <= azimuth_code_held_next;
      object_held        <= object_held_next;
    end
  end

endmodule

// ===== src/rctd_queue.sv =====
module rctd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rctd_pkg::job_t      push_job,
  input  logic                pop,
  output rctd_pkg::job_t      pop_job,
  output rctd_pkg::q_status_t q_status
);

  rctd_pkg::job_t entries [rctd_pkg::QUEUE_DEPTH];
  logic [rctd_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [rctd_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [rctd_pkg::QUEUE_CNT_W-1:0] count, count_next;

  assign q_status.full      = (count == rctd_pkg::QUEUE_CNT_W'(rctd_pkg::QUEUE_DEPTH));
  assign q_status.not_empty = (count != '0);
  assign pop_job            = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rctd_pkg::QUEUE_CNT_W'(rctd_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");
`endif

endmodule

// ===== src/rctd_back.sv =====
module rctd_back (
  input  logic                clk,
  input  logic                rst,
  input  rctd_pkg::job_t      pop_job,
  input  rctd_pkg::q_status_t q_status,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output rctd_pkg::out_word_t out_word
);

  rctd_pkg::out_word_t result;
  logic [14:0] az_diff;
  logic [12:0] el_diff;

  assign pop = q_status.not_empty && (!out_valid || !out_stall);

  assign az_diff = {5'd0, pop_job.azimuth_code} - 15'(rctd_pkg::AngleOffset);
  assign el_diff = {3'd0, pop_job.elevation_code} - 13'(rctd_pkg::AngleOffset);

  always_comb begin
    result.object_id          = pop_job.object_id;
    result.last_in_frame      = pop_job.last;
    result.range_cm           = '0;
    result.radial_speed_cm_s  = '0;
    result.azimuth_centideg   = '0;
    result.elevation_centideg = '0;
    if (pop_job.target) begin
      result.range_cm           = {pop_job.range_code, 2'b00};
      result.radial_speed_cm_s  = {pop_job.speed_code, 2'b00};
      result.azimuth_centideg   = $signed({az_diff[10:0], 4'b0000});
      result.elevation_centideg = $signed({el_diff[10:0], 2'b00});
    end
    result.target_count      = pop_job.announced;
    result.cycle_number      = pop_job.cycle_count;
    result.cycle_duration_us = {pop_job.duration_code, 6'd0};
    result.time_seconds      = pop_job.seconds;
    result.time_fraction     = pop_job.fraction;
    result.frame_number      = pop_job.frames;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== sim/radar_can_target_decoder_unit_test.sv =====
`timescale 1ns / 1ps

module radar_can_target_decoder_unit_test;

  localparam int CycleLimit = 400000;

  typedef struct {
    logic [10:0]         id;
    logic [63:0]         data;
    bit                  fixed;
    rctd_pkg::out_word_t word;
  } directed_row_t;

  logic      clk;
  logic      rst;
  logic      cfg_write;
  logic [10:0] cfg_data;
  logic      in_valid;
  logic      in_stall;
  rctd_pkg::in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  rctd_pkg::out_word_t out_word;

  // Decoder state as the block should hold it.
  logic [10:0] hdr_id = rctd_pkg::HEADER_ID_RESET;
  bit          in_targets = 1'b0;
  logic [7:0]  targets_left = '0;
  logic [7:0]  announced = '0;
  logic [39:0] cycle_held = '0;
  logic [11:0] duration_held = '0;
  logic [31:0] seconds_held = '0;
  logic [31:0] fraction_held = '0;
  logic [31:0] frames_done = '0;
  logic [12:0] range_held = '0;
  logic [11:0] speed_held = '0;
  logic [9:0]  azimuth_held = '0;
  logic [7:0]  object_held = '0;
  bit          message_used;

  rctd_pkg::hdr_mode_t hdr_next = rctd_pkg::HDR_TIMING;
  bit          want_frame1 = 1'b0;
  bit          steady = 1'b0;
  int          failures = 0;
  int          cycles = 0;

  rctd_pkg::out_word_t awaited_reports[$];
  directed_row_t       directed_rows[$];
  rctd_pkg::out_word_t blank_lit, empty_frame_lit, hdr_lit, unset_target_lit, max_target_lit;

  radar_can_target_decoder_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic rctd_pkg::out_word_t report_word(input logic [7:0] obj,
                                                      input bit is_last,
                                                      input bit is_target,
                                                      input logic [9:0] elev_code);
    rctd_pkg::out_word_t r;
    int az;
    int el;
    az = (int'(azimuth_held) - int'(rctd_pkg::AngleOffset)) * 16;
    el = (int'(elev_code) - int'(rctd_pkg::AngleOffset)) * 4;
    r.object_id          = obj;
    r.last_in_frame      = is_last;
    r.range_cm           = is_target ? {range_held, 2'b00} : '0;
    r.radial_speed_cm_s  = is_target ? {speed_held, 2'b00} : '0;
    r.azimuth_centideg   = is_target ? az[14:0] : '0;
    r.elevation_centideg = is_target ? el[12:0] : '0;
    r.target_count       = announced;
    r.cycle_number       = cycle_held;
    r.cycle_duration_us  = {duration_held, 6'b0};
    r.time_seconds       = seconds_held;
    r.time_fraction      = fraction_held;
    r.frame_number       = frames_done;
    return r;
  endfunction

  // Updates the decoder state for one accepted word; returns 1 when a report follows.
  function automatic bit decode_message(input rctd_pkg::in_word_t w,
                                        output rctd_pkg::out_word_t rep);
    logic [63:0] d;
    logic [11:0] upper;
    d = w.message_data;
    message_used = 1'b0;
    if (!in_targets) begin
      if (w.message_id != hdr_id) return 1'b0;
      case (d[63:62])
        rctd_pkg::HDR_TIMING: begin
          announced     = d[54:47];
          cycle_held    = d[46:7];
          duration_held = d[11:0];
          message_used  = 1'b1;
        end
        rctd_pkg::HDR_SECONDS: begin
          seconds_held = d[31:0];
          message_used = 1'b1;
        end
        rctd_pkg::HDR_FRACTION: begin
          fraction_held = d[31:0];
          message_used  = 1'b1;
          if (announced == 0) begin
            rep = report_word(8'd0, 1'b1, 1'b0, 10'd0);
            frames_done = frames_done + 1;
          end else begin
            rep = report_word(8'd0, 1'b0, 1'b0, 10'd0);
            targets_left = announced;
            in_targets = 1'b1;
          end
          return 1'b1;
        end
        default: ;
      endcase
      return 1'b0;
    end
    // The window's upper bound is formed in 12 bits and never wraps.
    upper = {1'b0, hdr_id} + rctd_pkg::TARGET_WINDOW;
    if (!({1'b0, w.message_id} > {1'b0, hdr_id} && {1'b0, w.message_id} < upper))
      return 1'b0;
    message_used = 1'b1;
    if (!d[0]) begin
      range_held   = d[13:1];
      speed_held   = d[50:39];
      azimuth_held = d[31:22];
      object_held  = 8'(w.message_id - hdr_id);
      return 1'b0;
    end
    targets_left = targets_left - 1;
    rep = report_word(object_held, targets_left == 0, 1'b1, d[46:37]);
    if (targets_left == 0) begin
      frames_done = frames_done + 1;
      in_targets = 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly well-formed headers and target pairs, with noise and broken sequences mixed in.
  function automatic rctd_pkg::in_word_t next_message();
    rctd_pkg::in_word_t w;
    logic [11:0] upper;
    int unsigned roll;
    int unsigned hi;
    w.message_id   = 11'($urandom);
    w.message_data = {$urandom, $urandom};
    roll = $urandom_range(99, 0);
    if (roll < 12) return w;
    if (!in_targets) begin
      w.message_id = hdr_id;
      if (roll >= 20) begin
        w.message_data[63:62] = hdr_next;
        hdr_next = (hdr_next == rctd_pkg::HDR_FRACTION) ? rctd_pkg::HDR_TIMING :
                   rctd_pkg::hdr_mode_t'(hdr_next + 2'd1);
      end
      // Keep most frames short; a full-range count shows up now and then.
      if (w.message_data[63:62] == rctd_pkg::HDR_TIMING && $urandom_range(59, 0) != 0)
        w.message_data[54:47] = 8'($urandom_range(4, 0));
    end else if (hdr_id != 11'h7FF) begin
      upper = {1'b0, hdr_id} + rctd_pkg::TARGET_WINDOW;
      hi = (upper > 12'h800) ? 2047 : int'(upper) - 1;
      w.message_id = 11'($urandom_range(hi, int'(hdr_id) + 1));
      if (roll >= 20) begin
        w.message_data[0] = want_frame1;
        want_frame1 = !want_frame1;
      end
    end
    return w;
  endfunction

  function automatic void add_row(input logic [10:0] id, input logic [63:0] data,
                                  input bit fixed, input rctd_pkg::out_word_t word);
    directed_row_t row;
    row.id    = id;
    row.data  = data;
    row.fixed = fixed;
    row.word  = word;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  task automatic send_word(input rctd_pkg::in_word_t w, input bit fixed,
                           input rctd_pkg::out_word_t fixed_word);
    rctd_pkg::out_word_t predicted;
    bit produced;
    while (!steady && $urandom_range(99, 0) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    produced = decode_message(w, predicted);
    if (fixed) awaited_reports.insert(awaited_reports.size(), fixed_word);
    else if (produced) awaited_reports.insert(awaited_reports.size(), predicted);
  endtask

  task automatic write_header_id(input logic [10:0] value);
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    // Ignored words may still be in flight behind the last report.
    repeat (6) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    hdr_id = value;
  endtask

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  task automatic check_report(input rctd_pkg::out_word_t got);
    rctd_pkg::out_word_t want;
    if (awaited_reports.size() == 0) begin
      $error("report word with none expected: %h", got);
      failures++;
      return;
    end
    want = awaited_reports.pop_front();
    compare_field("object_id", want.object_id, got.object_id);
    compare_field("last_in_frame", want.last_in_frame, got.last_in_frame);
    compare_field("range_cm", want.range_cm, got.range_cm);
    compare_field("radial_speed_cm_s", want.radial_speed_cm_s, got.radial_speed_cm_s);
    compare_field("azimuth_centideg", {want.azimuth_centideg}, {got.azimuth_centideg});
    compare_field("elevation_centideg", {want.elevation_centideg}, {got.elevation_centideg});
    compare_field("target_count", want.target_count, got.target_count);
    compare_field("cycle_number", want.cycle_number, got.cycle_number);
    compare_field("cycle_duration_us", want.cycle_duration_us, got.cycle_duration_us);
    compare_field("time_seconds", want.time_seconds, got.time_seconds);
    compare_field("time_fraction", want.time_fraction, got.time_fraction);
    compare_field("frame_number", want.frame_number, got.frame_number);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) check_report(out_word);
      out_stall <= !steady && ($urandom_range(99, 0) < 16);
    end
  end

  initial begin
    logic [10:0] settings [8];
    int used;
    int tried;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    settings  = '{11'h000, 11'h400, 11'h7FF, 11'h400, 11'h000, 11'h7A0, 11'h000, 11'h400};

    blank_lit       = '0;
    empty_frame_lit = '0;
    empty_frame_lit.last_in_frame = 1'b1;
    hdr_lit = '0;
    hdr_lit.target_count      = 8'd3;
    hdr_lit.cycle_number      = 40'hFF_FFFF_FFFF;
    hdr_lit.cycle_duration_us = 18'h3FFC0;
    hdr_lit.time_seconds      = 32'hFFFF_FFFF;
    hdr_lit.time_fraction     = 32'hFFFF_FFFF;
    hdr_lit.frame_number      = 32'd1;
    unset_target_lit = hdr_lit;
    unset_target_lit.azimuth_centideg   = -15'sd8176;
    unset_target_lit.elevation_centideg = -13'sd2044;
    max_target_lit = hdr_lit;
    max_target_lit.object_id          = 8'hFE;
    max_target_lit.range_cm           = 15'd32764;
    max_target_lit.radial_speed_cm_s  = 14'd16380;
    max_target_lit.azimuth_centideg   = 15'sd8192;
    max_target_lit.elevation_centideg = 13'sd2048;

    // A fraction word straight after reset closes an empty frame with reset values.
    add_row(11'h400, {rctd_pkg::HDR_FRACTION, 62'h0}, 1'b1, empty_frame_lit);
    add_row(11'h3FF, {rctd_pkg::HDR_TIMING, 7'h0, 8'd9, 40'h1, 7'h1}, 1'b0, blank_lit);
    add_row(11'h400, {rctd_pkg::HDR_RESERVED, 62'h3FFF_FFFF_FFFF_FFFF}, 1'b0, blank_lit);
    add_row(11'h400, {rctd_pkg::HDR_TIMING, 7'h0, 8'd3, 40'hFF_FFFF_FFFF, 7'h7F},
            1'b0, blank_lit);
    add_row(11'h400, {rctd_pkg::HDR_SECONDS, 30'h0, 32'hFFFF_FFFF}, 1'b0, blank_lit);
    add_row(11'h400, {rctd_pkg::HDR_FRACTION, 30'h0, 32'hFFFF_FFFF}, 1'b1, hdr_lit);
    // Header identifier, window edge and a lower identifier are all dropped here.
    add_row(11'h400, 64'h0, 1'b0, blank_lit);
    add_row(11'h4FF, 64'h1, 1'b0, blank_lit);
    add_row(11'h3FF, 64'h1, 1'b0, blank_lit);
    // A second-half word with no first half reports the reset codes.
    add_row(11'h401, 64'h1, 1'b1, unset_target_lit);
    add_row(11'h4FE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, blank_lit);
    add_row(11'h402, 64'h0000_7FE0_0000_0001, 1'b1, max_target_lit);
    add_row(11'h410, 64'h0005_5500_7FC0_2468, 1'b0, blank_lit);
    add_row(11'h410, 64'h0000_3FE0_0000_0001, 1'b0, blank_lit);
    add_row(11'h400, {rctd_pkg::HDR_TIMING, 7'h55, 8'd0, 40'h12_3456_789A, 7'h2B},
            1'b0, blank_lit);
    add_row(11'h400, {rctd_pkg::HDR_FRACTION, 30'h2AAA_AAAA, 32'h8000_0001},
            1'b0, blank_lit);
    add_row(11'h400, {rctd_pkg::HDR_TIMING, 7'h0, 8'd2, 40'h0, 7'h0}, 1'b0, blank_lit);
    add_row(11'h400, {rctd_pkg::HDR_FRACTION, 62'h1}, 1'b0, blank_lit);
    // Leaves a frame open so the next identifier change lands mid-frame.
    add_row(11'h420, 64'h8000_0000_0000_1234, 1'b0, blank_lit);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word({directed_rows[i].id, directed_rows[i].data}, directed_rows[i].fixed,
                directed_rows[i].word);

    for (int p = 0; p < 8; p++) begin
      write_header_id((p == 4 || p == 6) ? 11'($urandom) : settings[p]);
      steady = (p == 3);
      used = 0;
      tried = 0;
      while (used < 140 && tried < 200) begin
        send_word(next_message(), 1'b0, blank_lit);
        if (message_used) used++;
        tried++;
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && awaited_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
